/* rtl/tcphsr_pkg.sv */
// shared types and constants for the tcp handshake splice rewriter
package tcphsr_pkg;

    localparam int TABLE_DEPTH_DEF = 2048;
    localparam int KEY_W           = 96;
    localparam int ENTRY_W         = KEY_W + 64;

    localparam logic [7:0] FLAG_ACK = 8'h10;
    localparam logic [7:0] FLAG_SYN = 8'h02;

    localparam logic [1:0] OPT_NONE      = 2'd0;
    localparam logic [1:0] OPT_TS_NODATA = 2'd1;

    localparam logic [3:0] MIN_HDR_WORDS = 4'd8;

    // packet classes
    typedef enum logic [2:0] {
        CLS_PASS,
        CLS_SYNACK,
        CLS_NOTS_DROP,
        CLS_CREATE,
        CLS_LOOKUP
    } t_cls;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_SUM_OLD,
        ST_SUM_NEW,
        ST_FOLD,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic resolve;
        logic sum_old;
        logic sum_new;
        logic fold;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

/* rtl/tcphsr_if.sv */
// item channels: parsed packet in, rewritten result out
interface tcphsr_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] tcp_sport;
    logic [15:0] tcp_dport;
    logic [3:0]  header_words;
    logic [7:0]  tcp_flags;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic [1:0]  option_status;
    logic [15:0] checksum_in;

    modport source (output valid, src_ip, dst_ip, tcp_sport, tcp_dport, header_words,
                    tcp_flags, seq_number, ack_number, ts_value, ts_echo,
                    option_status, checksum_in, input ready);
    modport sink   (input valid, src_ip, dst_ip, tcp_sport, tcp_dport, header_words,
                    tcp_flags, seq_number, ack_number, ts_value, ts_echo,
                    option_status, checksum_in, output ready);
endinterface

interface tcphsr_res_if;
    logic        valid;
    logic        ready;
    logic        verdict;
    logic [7:0]  flags_out;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [31:0] echo_out;
    logic [15:0] checksum_out;

    modport source (output valid, verdict, flags_out, seq_out, ack_out, echo_out,
                    checksum_out, input ready);
    modport sink   (input valid, verdict, flags_out, seq_out, ack_out, echo_out,
                    checksum_out, output ready);
endinterface

/* rtl/tcphsr_ctrl.sv */
// controller state machine sequencing capture, table scan, rewrite and output
module tcphsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tcphsr_pkg::t_sts  i_sts,
    output tcphsr_pkg::t_cmd  o_cmd
);

    tcphsr_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcphsr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcphsr_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = tcphsr_pkg::ST_SCAN;
            end
            tcphsr_pkg::ST_SCAN: begin
                if (i_sts.scan_done) n_state = tcphsr_pkg::ST_RESOLVE;
            end
            tcphsr_pkg::ST_RESOLVE: n_state = tcphsr_pkg::ST_SUM_OLD;
            tcphsr_pkg::ST_SUM_OLD: n_state = tcphsr_pkg::ST_SUM_NEW;
            tcphsr_pkg::ST_SUM_NEW: n_state = tcphsr_pkg::ST_FOLD;
            tcphsr_pkg::ST_FOLD:    n_state = tcphsr_pkg::ST_OUT;
            tcphsr_pkg::ST_OUT: begin
                if (i_out_ready) n_state = tcphsr_pkg::ST_IDLE;
            end
            default: n_state = tcphsr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            tcphsr_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            tcphsr_pkg::ST_SCAN:    o_cmd.scan    = 1'b1;
            tcphsr_pkg::ST_RESOLVE: o_cmd.resolve = 1'b1;
            tcphsr_pkg::ST_SUM_OLD: o_cmd.sum_old = 1'b1;
            tcphsr_pkg::ST_SUM_NEW: o_cmd.sum_new = 1'b1;
            tcphsr_pkg::ST_FOLD:    o_cmd.fold    = 1'b1;
            tcphsr_pkg::ST_OUT:     o_out_valid   = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/tcphsr_dp.sv */
// datapath: item registers, connection table, rewrite and checksum update
module tcphsr_dp #(
    parameter int TABLE_DEPTH = tcphsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [31:0]       i_cfg_wr_data,
    input  tcphsr_pkg::t_cmd  i_cmd,
    output tcphsr_pkg::t_sts  o_sts,
    input  logic [31:0]       i_src_ip,
    input  logic [31:0]       i_dst_ip,
    input  logic [15:0]       i_tcp_sport,
    input  logic [15:0]       i_tcp_dport,
    input  logic [3:0]        i_header_words,
    input  logic [7:0]        i_tcp_flags,
    input  logic [31:0]       i_seq_number,
    input  logic [31:0]       i_ack_number,
    input  logic [31:0]       i_ts_value,
    input  logic [31:0]       i_ts_echo,
    input  logic [1:0]        i_option_status,
    input  logic [15:0]       i_checksum_in,
    output logic              o_verdict,
    output logic [7:0]        o_flags_out,
    output logic [31:0]       o_seq_out,
    output logic [31:0]       o_ack_out,
    output logic [31:0]       o_echo_out,
    output logic [15:0]       o_checksum_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW:0] DEPTH_C = (AW+1)'(TABLE_DEPTH);

    logic [31:0] r_ts_start;
    logic [31:0] r_sip, r_dip, r_seq, r_ack, r_tsv, r_echo;
    logic [15:0] r_sport, r_dport, r_csum;
    logic [3:0]  r_words;
    logic [7:0]  r_flags;
    logic [1:0]  r_opt;

    logic [tcphsr_pkg::ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic [tcphsr_pkg::ENTRY_W-1:0] r_rd;
    logic [AW-1:0] r_rd_idx, r_hit_idx;
    logic [AW:0]   r_addr, r_count;
    logic          r_rd_vld, r_found;
    logic [31:0]   r_hit_delta, r_hit_tsv;

    logic          r_drop, r_pass;
    logic [7:0]    r_f2;
    logic [31:0]   r_s2, r_a2, r_e2;
    logic [19:0]   r_sum;

    tcphsr_pkg::t_cls cls;
    logic [tcphsr_pkg::KEY_W-1:0] key;
    logic need_scan, match_now, issue, mem_we;
    logic [AW-1:0] wr_addr;
    logic [16:0] fold1;
    logic [15:0] fold2, acc, cs_new;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_start <= '0;
        end else if (i_cfg_wr_en) begin
            r_ts_start <= i_cfg_wr_data;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sip   <= i_src_ip;
            r_dip   <= i_dst_ip;
            r_sport <= i_tcp_sport;
            r_dport <= i_tcp_dport;
            r_words <= i_header_words;
            r_flags <= i_tcp_flags;
            r_seq   <= i_seq_number;
            r_ack   <= i_ack_number;
            r_tsv   <= i_ts_value;
            r_echo  <= i_ts_echo;
            r_opt   <= i_option_status;
            r_csum  <= i_checksum_in;
        end
    end

    // packet class
    always_comb begin
        if (r_words < tcphsr_pkg::MIN_HDR_WORDS || (r_flags & tcphsr_pkg::FLAG_ACK) == 8'h00)
            cls = tcphsr_pkg::CLS_PASS;
        else if ((r_flags & tcphsr_pkg::FLAG_SYN) != 8'h00)
            cls = tcphsr_pkg::CLS_SYNACK;
        else if (r_opt == tcphsr_pkg::OPT_NONE)
            cls = tcphsr_pkg::CLS_NOTS_DROP;
        else if (r_echo == r_ts_start && r_opt == tcphsr_pkg::OPT_TS_NODATA)
            cls = tcphsr_pkg::CLS_CREATE;
        else
            cls = tcphsr_pkg::CLS_LOOKUP;
    end

    // scan control: one table entry read per cycle over the filled part, until a match
    assign key       = {r_sip, r_dip, r_sport, r_dport};
    assign need_scan = (cls == tcphsr_pkg::CLS_CREATE) || (cls == tcphsr_pkg::CLS_LOOKUP);
    assign match_now = r_rd_vld && (r_rd[tcphsr_pkg::ENTRY_W-1 -: tcphsr_pkg::KEY_W] == key);
    assign issue     = need_scan && !r_found && !match_now && (r_addr < r_count);
    assign o_sts.scan_done = !need_scan || r_found || (!r_rd_vld && r_addr >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else if (i_cmd.capture) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= issue;
            if (issue) r_addr <= r_addr + 1'b1;
            if (match_now && !r_found) r_found <= 1'b1;
        end
    end

    // hit capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && match_now && !r_found) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_delta <= r_rd[63:32];
            r_hit_tsv   <= r_rd[31:0];
        end
    end

    // table insert: overwrite on hit, else append while room remains
    assign mem_we  = i_cmd.resolve && (cls == tcphsr_pkg::CLS_CREATE) &&
                     (r_found || r_count < DEPTH_C);
    assign wr_addr = r_found ? r_hit_idx : r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[wr_addr] <= {key, r_ack, r_tsv};
        if (i_cmd.scan && issue) begin
            r_rd     <= r_mem[r_addr[AW-1:0]];
            r_rd_idx <= r_addr[AW-1:0];
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (mem_we && !r_found) begin
            r_count <= r_count + 1'b1;
        end
    end

    // rewrite
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_drop <= 1'b0;
            r_pass <= 1'b0;
            r_f2   <= r_flags;
            r_s2   <= r_seq;
            r_a2   <= r_ack;
            r_e2   <= r_echo;
            case (cls)
                tcphsr_pkg::CLS_PASS:      r_pass <= 1'b1;
                tcphsr_pkg::CLS_SYNACK:    r_f2   <= r_flags & ~tcphsr_pkg::FLAG_SYN;
                tcphsr_pkg::CLS_NOTS_DROP: r_drop <= 1'b1;
                tcphsr_pkg::CLS_CREATE: begin
                    r_f2 <= (r_flags & ~tcphsr_pkg::FLAG_ACK) | tcphsr_pkg::FLAG_SYN;
                    r_s2 <= r_seq - 32'd1;
                    r_a2 <= '0;
                    r_e2 <= '0;
                end
                tcphsr_pkg::CLS_LOOKUP: begin
                    if (r_found) begin
                        r_a2 <= r_ack - r_hit_delta;
                        r_e2 <= r_hit_tsv;
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                default: r_drop <= 1'b1;
            endcase
        end
    end

    // checksum sums: removed halves, then added halves
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_old) begin
            r_sum <= {4'h0, ~r_csum} + {4'h0, ~{8'h00, r_flags}}
                   + {4'h0, ~r_seq[31:16]} + {4'h0, ~r_seq[15:0]}
                   + {4'h0, ~r_ack[31:16]} + {4'h0, ~r_ack[15:0]}
                   + {4'h0, ~r_echo[31:16]} + {4'h0, ~r_echo[15:0]};
        end else if (i_cmd.sum_new) begin
            r_sum <= r_sum + 20'(r_f2)
                   + 20'(r_s2[31:16]) + 20'(r_s2[15:0])
                   + 20'(r_a2[31:16]) + 20'(r_a2[15:0])
                   + 20'(r_e2[31:16]) + 20'(r_e2[15:0]);
        end
    end

    // fold to ones' complement and finish
    assign fold1  = 17'(r_sum[15:0]) + 17'(r_sum[19:16]);
    assign fold2  = fold1[15:0] + 16'(fold1[16]);
    assign acc    = (fold2 == 16'hFFFF) ? 16'h0000 : fold2;
    assign cs_new = (acc == 16'h0000) ? 16'h0000 : ~acc;

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.fold) begin
            o_verdict      <= r_drop;
            o_flags_out    <= r_drop ? 8'h00  : r_f2;
            o_seq_out      <= r_drop ? 32'h0  : r_s2;
            o_ack_out      <= r_drop ? 32'h0  : r_a2;
            o_echo_out     <= r_drop ? 32'h0  : r_e2;
            o_checksum_out <= r_drop ? 16'h0  : (r_pass ? r_csum : cs_new);
        end
    end

endmodule

/* rtl/tcp_handshake_splice_rewriter.sv */
// top level of the tcp handshake splice rewriter
// One item is taken at a time. An item that needs the connection table (an
// ACK without SYN, with a timestamp option) sweeps the stored connections in
// order through the single table read port, one read per cycle until a match.
// The result waits in its output register until taken, and the next item is
// accepted the cycle after. The table starts empty after reset.
module tcp_handshake_splice_rewriter #(
    parameter int TABLE_DEPTH = tcphsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    tcphsr_pkt_if.sink    i_pkt,
    tcphsr_res_if.source  o_res
);

    tcphsr_pkg::t_cmd cmd;
    tcphsr_pkg::t_sts sts;

    // sequencing
    tcphsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pkt.valid),
        .o_in_ready  (i_pkt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // table and rewrite
    tcphsr_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_src_ip        (i_pkt.src_ip),
        .i_dst_ip        (i_pkt.dst_ip),
        .i_tcp_sport     (i_pkt.tcp_sport),
        .i_tcp_dport     (i_pkt.tcp_dport),
        .i_header_words  (i_pkt.header_words),
        .i_tcp_flags     (i_pkt.tcp_flags),
        .i_seq_number    (i_pkt.seq_number),
        .i_ack_number    (i_pkt.ack_number),
        .i_ts_value      (i_pkt.ts_value),
        .i_ts_echo       (i_pkt.ts_echo),
        .i_option_status (i_pkt.option_status),
        .i_checksum_in   (i_pkt.checksum_in),
        .o_verdict       (o_res.verdict),
        .o_flags_out     (o_res.flags_out),
        .o_seq_out       (o_res.seq_out),
        .o_ack_out       (o_res.ack_out),
        .o_echo_out      (o_res.echo_out),
        .o_checksum_out  (o_res.checksum_out)
    );

endmodule

/* rtl/tcphsr_chk.sv */
// port-level checks for the rewriter, bound to the top level
module tcphsr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_verdict,
    input logic [7:0]  i_flags,
    input logic [31:0] i_seq,
    input logic [31:0] i_ack,
    input logic [31:0] i_echo,
    input logic [15:0] i_csum
);

    // pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before being taken");

    // no new item while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("item accepted while result pending");

    // dropped packets carry zero fields
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_verdict |-> i_flags == 8'h00 && i_seq == 32'h0 &&
            i_ack == 32'h0 && i_echo == 32'h0 && i_csum == 16'h0)
        else $error("drop result with non-zero fields");

    // block is free again after a result is taken
    a_free_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> i_in_ready)
        else $error("not ready after result taken");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind tcp_handshake_splice_rewriter tcphsr_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pkt.valid),
    .i_in_ready  (i_pkt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_verdict   (o_res.verdict),
    .i_flags     (o_res.flags_out),
    .i_seq       (o_res.seq_out),
    .i_ack       (o_res.ack_out),
    .i_echo      (o_res.echo_out),
    .i_csum      (o_res.checksum_out)
);
